/* rtl/gcs_pkg.sv */
// Shared types, codes and constants of the grouped convolution unit.
package gcs_pkg;

	localparam int MaxChannels = 16;
	localparam int MaxHeight   = 32;
	localparam int MaxWidth    = 32;
	localparam int MaxKernel   = 5;
	localparam int DataBits    = 16;

	localparam int ActDepth  = MaxChannels * MaxHeight * MaxWidth;
	localparam int WgtDepth  = MaxChannels * MaxChannels * MaxKernel * MaxKernel;
	localparam int ActAddrW  = $clog2(ActDepth);
	localparam int WgtAddrW  = $clog2(WgtDepth);
	localparam int BiasAddrW = $clog2(MaxChannels);

	localparam logic [1:0] ACTION_LOAD_ACT  = 2'd0;
	localparam logic [1:0] ACTION_LOAD_WGT  = 2'd1;
	localparam logic [1:0] ACTION_LOAD_BIAS = 2'd2;
	localparam logic [1:0] ACTION_COMPUTE   = 2'd3;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_BAD_CFG = 2'd1;
	localparam logic [1:0] STATUS_RANGE   = 2'd2;

	localparam logic [3:0] REG_IN_CHANNELS  = 4'd0;
	localparam logic [3:0] REG_IMAGE_HEIGHT = 4'd1;
	localparam logic [3:0] REG_IMAGE_WIDTH  = 4'd2;
	localparam logic [3:0] REG_OUT_CHANNELS = 4'd3;
	localparam logic [3:0] REG_KERNEL_H     = 4'd4;
	localparam logic [3:0] REG_KERNEL_W     = 4'd5;
	localparam logic [3:0] REG_PAD          = 4'd6;
	localparam logic [3:0] REG_GROUPS       = 4'd7;

	typedef struct packed {
		logic [4:0] in_channels;
		logic [5:0] image_height;
		logic [5:0] image_width;
		logic [4:0] out_channels;
		logic [2:0] kernel_height;
		logic [2:0] kernel_width;
		logic [2:0] pad_amount;
		logic [4:0] group_count;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [13:0]       position;
		logic signed [15:0] sample;
		logic              in_range;
	} item_t;

endpackage

/* rtl/gcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* rtl/gcs_front.sv */
// Front end: accepts input beats, classifies loads and queues them for the back end.
module gcs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [13:0]         position,
	input  logic signed [15:0]  sample,
	output gcs_pkg::item_t      head,
	output logic                head_valid,
	input  logic                pop
);
	import gcs_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	item_t      entry;

	always_comb begin
		entry.action   = action;
		entry.position = position;
		entry.sample   = sample;
		unique case (action)
			ACTION_LOAD_WGT:  entry.in_range = ({18'd0, position} < WgtDepth);
			ACTION_LOAD_BIAS: entry.in_range = ({18'd0, position} < MaxChannels);
			default:          entry.in_range = 1'b1;
		endcase
	end

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !pop) |=> !in_ready) else $error("full queue took a beat");
`endif
endmodule

/* rtl/gcs_back.sv */
// Back end: performs loads, decodes compute positions and runs the shared MAC.
module gcs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  gcs_pkg::cfg_t       cfg,
	input  gcs_pkg::item_t      head,
	input  logic                head_valid,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  out_value,
	output logic [13:0]         out_position,
	output logic [1:0]          status
);
	import gcs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_DIVG, ST_RANGE, ST_DIVP, ST_DIVW,
		ST_DIVO, ST_SETUP, ST_MAC, ST_DRAIN, ST_ROUND, ST_EMIT
	} state_t;

	state_t state_q;
	logic [13:0] pos_q;
	logic [1:0]  res_status_q;
	logic signed [15:0] res_value_q;
	logic [4:0]  rem_ci_q, rem_co_q, gin_q, gout_q;
	logic [10:0] plane_q;
	logic [13:0] rem_q;
	logic [3:0]  oc_q, t_q, grp_q;
	logic [4:0]  oh_q, ow_q;
	logic [4:0]  ic0_q;
	logic [7:0]  wbase_q;
	logic [3:0]  ic_q;
	logic [2:0]  r_q, c_q;
	logic signed [40:0] acc_q;
	logic        out_valid_q;
	logic signed [15:0] out_value_q;
	logic [13:0] out_position_q;
	logic [1:0]  status_q;
	logic signed [15:0] bias_q [MaxChannels];

	logic        v_s1_q, v_s2_q, v_s3_q;
	logic [10:0] rowa_s1;
	logic [10:0] rowb_s1;
	logic [4:0]  iw_s1;
	logic [2:0]  c_s1;
	logic signed [31:0] prod_s3;

	logic        cfg_range_ok;
	logic signed [7:0] ih, iw;
	logic        tap_in;
	logic        last_c, last_r, last_ic;
	logic [4:0]  chan_a;
	logic [7:0]  chan_w;
	logic [16:0] ai_full;
	logic [13:0] wi_full;
	logic [15:0] act_rd, wgt_rd;
	logic [15:0] total;
	logic signed [40:0] rnd;
	logic signed [40:0] shf;
	logic        emit_free;
	logic        act_we, wgt_we;

	assign cfg_range_ok =
		(cfg.in_channels != 5'd0) && (cfg.in_channels <= 5'd16) &&
		(cfg.out_channels != 5'd0) && (cfg.out_channels <= 5'd16) &&
		(cfg.image_height != 6'd0) && (cfg.image_height <= 6'd32) &&
		(cfg.image_width != 6'd0) && (cfg.image_width <= 6'd32) &&
		(cfg.kernel_height != 3'd0) && (cfg.kernel_height <= 3'd5) &&
		(cfg.kernel_width != 3'd0) && (cfg.kernel_width <= 3'd5) &&
		(cfg.group_count != 5'd0) && (cfg.group_count <= 5'd16);

	assign pop    = head_valid && (state_q == ST_IDLE);
	assign act_we = pop && (head.action == ACTION_LOAD_ACT);
	assign wgt_we = pop && (head.action == ACTION_LOAD_WGT) && head.in_range;
	assign total  = {11'd0, cfg.out_channels} * {5'd0, plane_q};

	// Tap generation for the current (input channel, kernel row, kernel column).
	assign ih = $signed({3'd0, oh_q}) + $signed({5'd0, r_q}) - $signed({5'd0, cfg.pad_amount});
	assign iw = $signed({3'd0, ow_q}) + $signed({5'd0, c_q}) - $signed({5'd0, cfg.pad_amount});
	assign tap_in = !ih[7] && (ih[6:0] < {1'b0, cfg.image_height}) &&
		!iw[7] && (iw[6:0] < {1'b0, cfg.image_width});
	assign last_c  = ({2'd0, c_q} == {3'd0, cfg.kernel_width} - 5'd1);
	assign last_r  = ({2'd0, r_q} == {3'd0, cfg.kernel_height} - 5'd1);
	assign last_ic = ({1'b0, ic_q} == gin_q - 5'd1);
	assign chan_a  = ic0_q + {1'b0, ic_q};
	assign chan_w  = wbase_q + {4'd0, ic_q};

	assign ai_full = rowa_s1 * {5'd0, cfg.image_width} + {6'd0, iw_s1};
	assign wi_full = rowb_s1[10:0] * cfg.kernel_width + {11'd0, c_s1};

	gcs_ram #(.WIDTH(DataBits), .DEPTH(ActDepth)) u_act_ram (
		.clk   (clk),
		.we    (act_we),
		.waddr (head.position[ActAddrW-1:0]),
		.wdata (head.sample),
		.raddr (ai_full[ActAddrW-1:0]),
		.rdata (act_rd)
	);

	gcs_ram #(.WIDTH(DataBits), .DEPTH(WgtDepth)) u_wgt_ram (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (head.position[WgtAddrW-1:0]),
		.wdata (head.sample),
		.raddr (wi_full[WgtAddrW-1:0]),
		.rdata (wgt_rd)
	);

	// MAC pipeline: tap registers, RAM read, product.
	always_ff @(posedge clk) begin
		rowa_s1 <= chan_a * cfg.image_height + {6'd0, ih[4:0]};
		rowb_s1 <= chan_w * cfg.kernel_height + {8'd0, r_q};
		iw_s1   <= iw[4:0];
		c_s1    <= c_q;
		prod_s3 <= $signed(act_rd) * $signed(wgt_rd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
		end else begin
			v_s1_q <= (state_q == ST_MAC) && tap_in;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
		end
	end

	assign rnd = acc_q + 41'sd128;
	assign shf = rnd >>> 8;
	assign emit_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MaxChannels; i++) begin
				bias_q[i] <= '0;
			end
		end else begin
			// A result taken while a new one is being loaded is replaced in the EMIT arm.
			if (out_valid_q && out_ready && !(state_q == ST_EMIT && emit_free)) begin
				out_valid_q <= 1'b0;
			end
			if (v_s3_q) begin
				acc_q <= acc_q + 41'(prod_s3);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						pos_q       <= head.position;
						res_value_q <= '0;
						if (head.action == ACTION_COMPUTE) begin
							state_q <= ST_CHECK;
						end else if (!head.in_range) begin
							res_status_q <= STATUS_RANGE;
							state_q      <= ST_EMIT;
						end else if (head.action == ACTION_LOAD_BIAS) begin
							bias_q[head.position[BiasAddrW-1:0]] <= head.sample;
						end
					end
				end
				ST_CHECK: begin
					rem_ci_q <= cfg.in_channels;
					rem_co_q <= cfg.out_channels;
					gin_q    <= '0;
					gout_q   <= '0;
					plane_q  <= 11'(cfg.image_height * cfg.image_width);
					if (cfg_range_ok) begin
						state_q <= ST_DIVG;
					end else begin
						res_status_q <= STATUS_BAD_CFG;
						state_q      <= ST_EMIT;
					end
				end
				ST_DIVG: begin
					if (rem_ci_q >= cfg.group_count) begin
						rem_ci_q <= rem_ci_q - cfg.group_count;
						gin_q    <= gin_q + 5'd1;
					end
					if (rem_co_q >= cfg.group_count) begin
						rem_co_q <= rem_co_q - cfg.group_count;
						gout_q   <= gout_q + 5'd1;
					end
					if (rem_ci_q < cfg.group_count && rem_co_q < cfg.group_count) begin
						if (rem_ci_q != 5'd0 || rem_co_q != 5'd0) begin
							res_status_q <= STATUS_BAD_CFG;
							state_q      <= ST_EMIT;
						end else begin
							state_q <= ST_RANGE;
						end
					end
				end
				ST_RANGE: begin
					rem_q <= pos_q;
					oc_q  <= '0;
					if ({2'd0, pos_q} >= total) begin
						res_status_q <= STATUS_RANGE;
						state_q      <= ST_EMIT;
					end else begin
						state_q <= ST_DIVP;
					end
				end
				ST_DIVP: begin
					oh_q <= '0;
					if (rem_q >= {3'd0, plane_q}) begin
						rem_q <= rem_q - {3'd0, plane_q};
						oc_q  <= oc_q + 4'd1;
					end else begin
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					t_q   <= oc_q;
					grp_q <= '0;
					if (rem_q >= {8'd0, cfg.image_width}) begin
						rem_q <= rem_q - {8'd0, cfg.image_width};
						oh_q  <= oh_q + 5'd1;
					end else begin
						ow_q    <= rem_q[4:0];
						state_q <= ST_DIVO;
					end
				end
				ST_DIVO: begin
					if ({1'b0, t_q} >= gout_q) begin
						t_q   <= t_q - gout_q[3:0];
						grp_q <= grp_q + 4'd1;
					end else begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					ic0_q   <= 5'(grp_q * gin_q);
					wbase_q <= 8'(oc_q * gin_q);
					acc_q   <= 41'(bias_q[oc_q]) <<< 8;
					ic_q    <= '0;
					r_q     <= '0;
					c_q     <= '0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (!last_c) begin
						c_q <= c_q + 3'd1;
					end else begin
						c_q <= '0;
						if (!last_r) begin
							r_q <= r_q + 3'd1;
						end else begin
							r_q <= '0;
							ic_q <= ic_q + 4'd1;
							if (last_ic) begin
								state_q <= ST_DRAIN;
							end
						end
					end
				end
				ST_DRAIN: begin
					if (!v_s1_q && !v_s2_q && !v_s3_q) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					res_status_q <= STATUS_OK;
					if (shf > 41'sd32767) begin
						res_value_q <= 16'sh7fff;
					end else if (shf < -41'sd32768) begin
						res_value_q <= 16'sh8000;
					end else begin
						res_value_q <= shf[15:0];
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_free) begin
						out_valid_q    <= 1'b1;
						out_value_q    <= res_value_q;
						out_position_q <= pos_q;
						status_q       <= res_status_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign out_position = out_position_q;
	assign status       = status_q;

`ifndef NO_ASSERTIONS
	a_tap_from_mac: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1_q |-> $past(state_q == ST_MAC)) else $error("tap issued outside MAC");
	a_round_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (!v_s1_q && !v_s2_q && !v_s3_q))
		else $error("rounding before pipeline drained");
	a_groups_divide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RANGE) |-> (rem_ci_q == 5'd0 && rem_co_q == 5'd0))
		else $error("group count does not divide channels");
	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !emit_free) |=> (state_q == ST_EMIT))
		else $error("result dropped while output busy");
`endif
endmodule

/* rtl/grouped_conv2d_same_size_unit.sv */
// Top level of the grouped same-size 2-D convolution unit.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_ready     action, position, sample
//   out      output     out_valid / out_ready   out_value, out_position, status
//   cfg      input      cfg_we (no wait)        cfg_index, cfg_data
//
// An in-range load is stored as it is popped; an out-of-range load reports a range status.
// A compute beat goes through configuration checking, group division, position decoding,
// the multiply-accumulate pass, pipeline drain and rounding. The MAC pass steps through
// every kernel tap of the group (input channels per group times kernel rows times kernel
// columns, up to 400) on the single shared MAC unit fed from the activation and weight RAMs.
// Reset clears the configuration registers to their defaults and the bias store to zero.
// The two-entry front queue keeps accepting beats while the back end computes or waits for
// the output register to be taken, and in_ready falls once both entries are occupied.
module grouped_conv2d_same_size_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [13:0]        position,
	input  logic signed [15:0] sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_value,
	output logic [13:0]        out_position,
	output logic [1:0]         status,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_index,
	input  logic [5:0]         cfg_data
);
	import gcs_pkg::*;

	cfg_t  cfg_q;
	item_t head;
	logic  head_valid;
	logic  pop;

	// Configuration registers; writes are masked to each register's width and
	// indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_channels   <= 5'd1;
			cfg_q.image_height  <= 6'd1;
			cfg_q.image_width   <= 6'd1;
			cfg_q.out_channels  <= 5'd1;
			cfg_q.kernel_height <= 3'd3;
			cfg_q.kernel_width  <= 3'd3;
			cfg_q.pad_amount    <= 3'd1;
			cfg_q.group_count   <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_CHANNELS:  cfg_q.in_channels   <= cfg_data[4:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height  <= cfg_data;
				REG_IMAGE_WIDTH:  cfg_q.image_width   <= cfg_data;
				REG_OUT_CHANNELS: cfg_q.out_channels  <= cfg_data[4:0];
				REG_KERNEL_H:     cfg_q.kernel_height <= cfg_data[2:0];
				REG_KERNEL_W:     cfg_q.kernel_width  <= cfg_data[2:0];
				REG_PAD:          cfg_q.pad_amount    <= cfg_data[2:0];
				REG_GROUPS:       cfg_q.group_count   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// The front end queues classified beats; the back end drains them one at a time.
	gcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.position   (position),
		.sample     (sample),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	gcs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.out_position (out_position),
		.status       (status)
	);
endmodule
